>>> design/nzt_pkg.sv
// ----------------------------------------------------------------------------
// nzt_pkg: shared types and constants of the nested zone timing tracker
// Field widths, event and result codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package nzt_pkg;

  localparam int unsigned THREAD_COUNT_DEF = 8;
  localparam int unsigned STACK_DEPTH_DEF  = 16;
  localparam int unsigned ZONE_COUNT_DEF   = 64;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned THREAD_W = 3;
  localparam int unsigned ZONE_W   = 6;
  localparam int unsigned TS_W     = 64;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned FNUM_W   = 32;
  // frame epoch stamped into the zone table, rolls over through a clearing pass
  localparam int unsigned EPOCH_W  = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_FRAME_START = 2'd0,
    MODE_FRAME_END   = 2'd1,
    MODE_ZONE_START  = 2'd2,
    MODE_ZONE_END    = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ZONE_CLOSED  = 3'd0,
    KIND_FRAME_CLOSED = 3'd1,
    KIND_EMPTY_END    = 3'd2,
    KIND_OVERFLOW     = 3'd3,
    KIND_NESTED_FRAME = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_RUN   = 2'd1,
    ST_DRAIN = 2'd2
  } state_e;

endpackage

>>> design/nzt_if.sv
// ----------------------------------------------------------------------------
// nzt_if: event and result channels of the nested zone timing tracker
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface nzt_evt_if;
  import nzt_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [THREAD_W-1:0] thread_id;
  logic [ZONE_W-1:0]   zone_id;
  logic [TS_W-1:0]     timestamp;

  modport source (output valid, mode, thread_id, zone_id, timestamp, input ready);
  modport sink   (input valid, mode, thread_id, zone_id, timestamp, output ready);
endinterface

interface nzt_res_if;
  import nzt_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [THREAD_W-1:0] out_thread;
  logic [ZONE_W-1:0]   out_zone;
  logic [TS_W-1:0]     start_time;
  logic [TS_W-1:0]     elapsed;
  logic [LEVEL_W-1:0]  level;
  logic [TS_W-1:0]     zone_total;
  logic [TS_W-1:0]     zone_max;
  logic [FNUM_W-1:0]   frame_number;

  modport source (output valid, kind, out_thread, out_zone, start_time, elapsed, level,
                  zone_total, zone_max, frame_number, input ready);
  modport sink   (input valid, kind, out_thread, out_zone, start_time, elapsed, level,
                  zone_total, zone_max, frame_number, output ready);
endinterface

>>> design/nested_zone_timing_tracker_core.sv
// ----------------------------------------------------------------------------
// nested_zone_timing_tracker_core: per-thread zone timing over trace frames
// Keeps a stack of open zones per thread, times zone and frame spans and
// accumulates per-thread, per-zone totals and peaks within a frame.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------------
//  evt_i    | in  | valid/ready   | mode, thread_id, zone_id, timestamp
//  res_o    | out | valid/ready   | kind, out_thread, out_zone, start_time,
//           |     |               | elapsed, level, zone_total, zone_max, frame_number
//  cfg      | in  | cfg_we_i      | cfg_wdata_i (recording stopped)
//
//  one item per cycle unless a stall, drain or clearing pass holds it; a result passes
//  stack read at acceptance, zone table read, table update into the output register;
//  after reset a clearing pass sweeps all THREAD_COUNT * 2**clog2(ZONE_COUNT) zone
//  table tags (512 by default) with ready low; every 65535th frame opening (first the
//  65536th after reset) rolls the epoch over, drains the pipeline and reruns the
//  pass; a stalled result holds the whole pipeline, so ready follows res_o.ready
// ----------------------------------------------------------------------------
module nested_zone_timing_tracker_core #(
  parameter int unsigned THREAD_COUNT = nzt_pkg::THREAD_COUNT_DEF,
  parameter int unsigned STACK_DEPTH  = nzt_pkg::STACK_DEPTH_DEF,
  parameter int unsigned ZONE_COUNT   = nzt_pkg::ZONE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  nzt_evt_if.sink    evt_i,
  nzt_res_if.source  res_o
);
  import nzt_pkg::*;

  localparam int unsigned TIW       = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int unsigned SIW       = $clog2(STACK_DEPTH);
  localparam int unsigned SPW       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ZIW       = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int unsigned STK_AW    = TIW + SIW;
  localparam int unsigned TBL_AW    = TIW + ZIW;
  localparam int unsigned STK_N     = THREAD_COUNT * (2 ** SIW);
  localparam int unsigned TBL_N     = THREAD_COUNT * (2 ** ZIW);
  localparam int unsigned ZONE_SPAN = 2 ** ZONE_W;

  // zone id to table slot, zone ids past the table fold back modulo ZONE_COUNT
  logic [ZIW-1:0] zslot_tbl [ZONE_SPAN];
  for (genvar gi = 0; gi < ZONE_SPAN; gi++) begin : g_zslot
    assign zslot_tbl[gi] = ZIW'(gi % ZONE_COUNT);
  end

  // --------------------------------------------------------------------------
  // control and frame state
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [TBL_AW-1:0]   clr_q, clr_d;
  logic                clr_last;
  logic                clr_active;
  logic                run_active;

  logic                rec_stop_q;
  logic                in_frame_q;
  logic [TS_W-1:0]     fst_q;
  logic [FNUM_W-1:0]   fc_q;
  logic [EPOCH_W-1:0]  epoch_q;
  logic [SPW-1:0]      sp_q [THREAD_COUNT];

  logic                adv;
  logic                acc;

  // item decode
  mode_e               mode;
  logic                thr_ok;
  logic [TIW-1:0]      thr_idx;
  logic [SPW-1:0]      sp_cur;
  logic [SPW-1:0]      sp_dec;
  logic                do_open, do_close, do_push, do_pop, has_res;
  kind_e               res_kind;
  logic [ZONE_W-1:0]   res_zone;
  logic [TS_W-1:0]     res_start;
  logic [FNUM_W-1:0]   res_fnum;
  logic [LEVEL_W-1:0]  res_level;
  logic                wrap;
  logic [STK_AW-1:0]   stk_waddr, stk_raddr;

  // stack memory
  logic [TS_W-1:0]     stk_ts_mem   [STK_N];
  logic [ZONE_W-1:0]   stk_zone_mem [STK_N];
  logic [TS_W-1:0]     st_rd_q;
  logic [ZONE_W-1:0]   zn_rd_q;

  // stage 1
  logic                s1_valid_q;
  kind_e               s1_kind_q;
  logic [THREAD_W-1:0] s1_thr_q;
  logic [TIW-1:0]      s1_tidx_q;
  logic [ZONE_W-1:0]   s1_zone_q;
  logic [TS_W-1:0]     s1_start_q;
  logic [TS_W-1:0]     s1_end_q;
  logic [LEVEL_W-1:0]  s1_level_q;
  logic [FNUM_W-1:0]   s1_fnum_q;
  logic [EPOCH_W-1:0]  s1_epoch_q;
  logic                is_pop1;
  logic [ZONE_W-1:0]   zone1;
  logic [TS_W-1:0]     start1;
  logic [TS_W-1:0]     el1;
  logic [TBL_AW-1:0]   tbl_raddr;

  // zone table memory
  logic [TS_W-1:0]     tbl_sum_mem  [TBL_N];
  logic [TS_W-1:0]     tbl_peak_mem [TBL_N];
  logic [EPOCH_W-1:0]  tbl_tag_mem  [TBL_N];
  logic [TS_W-1:0]     sum_rd_q, peak_rd_q;
  logic [EPOCH_W-1:0]  tag_rd_q;

  // stage 2
  logic                s2_valid_q;
  kind_e               s2_kind_q;
  logic [THREAD_W-1:0] s2_thr_q;
  logic [ZONE_W-1:0]   s2_zone_q;
  logic [TS_W-1:0]     s2_start_q;
  logic [TS_W-1:0]     s2_el_q;
  logic [LEVEL_W-1:0]  s2_level_q;
  logic [FNUM_W-1:0]   s2_fnum_q;
  logic [EPOCH_W-1:0]  s2_epoch_q;
  logic [TBL_AW-1:0]   s2_addr_q;
  logic                is_pop2;
  logic                fwd, hit;
  logic [TS_W-1:0]     prev_sum, prev_peak, new_sum, new_peak;
  logic                tbl_we;

  // last table write, for an update that reads the entry being written
  logic                lw_valid_q;
  logic [TBL_AW-1:0]   lw_addr_q;
  logic [TS_W-1:0]     lw_sum_q, lw_peak_q;
  logic [EPOCH_W-1:0]  lw_epoch_q;

  // output register
  logic                out_valid_q;
  kind_e               out_kind_q;
  logic [THREAD_W-1:0] out_thr_q;
  logic [ZONE_W-1:0]   out_zone_q;
  logic [TS_W-1:0]     out_start_q;
  logic [TS_W-1:0]     out_el_q;
  logic [LEVEL_W-1:0]  out_level_q;
  logic [TS_W-1:0]     out_total_q;
  logic [TS_W-1:0]     out_max_q;
  logic [FNUM_W-1:0]   out_fnum_q;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign clr_last = (clr_q == TBL_AW'(TBL_N - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (acc && wrap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid_q && !s2_valid_q) begin
          state_d = ST_CLEAR;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    clr_active = (state_q == ST_CLEAR);
    run_active = (state_q == ST_RUN);
    clr_d      = (clr_active && !clr_last) ? clr_q + 1'b1 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // whole pipeline moves together whenever the output register can take a step
  assign adv         = !out_valid_q || res_o.ready;
  assign evt_i.ready = adv && run_active;
  assign acc         = evt_i.valid && evt_i.ready;

  // --------------------------------------------------------------------------
  // item decode against frame and stack state
  // --------------------------------------------------------------------------
  always_comb begin
    mode      = mode_e'(evt_i.mode);
    thr_ok    = 32'(evt_i.thread_id) < THREAD_COUNT;
    thr_idx   = TIW'(evt_i.thread_id);
    sp_cur    = sp_q[thr_idx];
    sp_dec    = sp_cur - 1'b1;
    do_open   = 1'b0;
    do_close  = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    has_res   = 1'b0;
    res_kind  = KIND_ZONE_CLOSED;
    res_zone  = '0;
    res_start = evt_i.timestamp;
    res_fnum  = '0;
    res_level = '0;
    if (!rec_stop_q) begin
      unique case (mode)
        MODE_FRAME_START: begin
          do_open = 1'b1;
          if (in_frame_q) begin
            has_res  = 1'b1;
            res_kind = KIND_NESTED_FRAME;
          end
        end
        MODE_FRAME_END: begin
          if (in_frame_q) begin
            do_close  = 1'b1;
            has_res   = 1'b1;
            res_kind  = KIND_FRAME_CLOSED;
            res_start = fst_q;
            res_fnum  = fc_q + 1'b1;
          end
        end
        MODE_ZONE_START: begin
          if (in_frame_q && thr_ok) begin
            if (sp_cur == SPW'(STACK_DEPTH)) begin
              has_res  = 1'b1;
              res_kind = KIND_OVERFLOW;
              res_zone = evt_i.zone_id;
            end else begin
              do_push = 1'b1;
            end
          end
        end
        MODE_ZONE_END: begin
          if (in_frame_q && thr_ok) begin
            has_res = 1'b1;
            if (sp_cur == '0) begin
              res_kind = KIND_EMPTY_END;
            end else begin
              do_pop    = 1'b1;
              res_kind  = KIND_ZONE_CLOSED;
              res_level = LEVEL_W'(sp_dec);
            end
          end
        end
      endcase
    end
    wrap      = do_open && (epoch_q == '1);
    stk_waddr = {thr_idx, sp_cur[SIW-1:0]};
    stk_raddr = {thr_idx, sp_dec[SIW-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_stop_q <= 1'b0;
      in_frame_q <= 1'b0;
      fst_q      <= '0;
      fc_q       <= '0;
      epoch_q    <= '0;
      for (int t = 0; t < THREAD_COUNT; t++) begin
        sp_q[t] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        rec_stop_q <= cfg_wdata_i;
      end
      if (acc) begin
        if (do_open) begin
          in_frame_q <= 1'b1;
          fst_q      <= evt_i.timestamp;
          // epoch zero marks a cleared tag, so rollover skips it
          epoch_q    <= wrap ? EPOCH_W'(1) : epoch_q + 1'b1;
          for (int t = 0; t < THREAD_COUNT; t++) begin
            sp_q[t] <= '0;
          end
        end
        if (do_close) begin
          in_frame_q <= 1'b0;
          fc_q       <= fc_q + 1'b1;
        end
        if (do_push) begin
          sp_q[thr_idx] <= sp_cur + 1'b1;
        end
        if (do_pop) begin
          sp_q[thr_idx] <= sp_dec;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // open zone stacks
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (acc && do_push) begin
      stk_ts_mem[stk_waddr]   <= evt_i.timestamp;
      stk_zone_mem[stk_waddr] <= evt_i.zone_id;
    end
    if (acc && do_pop) begin
      st_rd_q <= stk_ts_mem[stk_raddr];
      zn_rd_q <= stk_zone_mem[stk_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: popped entry, span and table lookup
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q  <= res_kind;
      s1_thr_q   <= evt_i.thread_id;
      s1_tidx_q  <= thr_idx;
      s1_zone_q  <= res_zone;
      s1_start_q <= res_start;
      s1_end_q   <= evt_i.timestamp;
      s1_level_q <= res_level;
      s1_fnum_q  <= res_fnum;
      s1_epoch_q <= epoch_q;
    end
  end

  always_comb begin
    is_pop1   = (s1_kind_q == KIND_ZONE_CLOSED);
    zone1     = is_pop1 ? zn_rd_q : s1_zone_q;
    start1    = is_pop1 ? st_rd_q : s1_start_q;
    el1       = (is_pop1 || s1_kind_q == KIND_FRAME_CLOSED) ? s1_end_q - start1 : '0;
    tbl_raddr = {s1_tidx_q, zslot_tbl[zone1]};
  end

  // --------------------------------------------------------------------------
  // zone table
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_rd_q  <= tbl_sum_mem[tbl_raddr];
      peak_rd_q <= tbl_peak_mem[tbl_raddr];
      tag_rd_q  <= tbl_tag_mem[tbl_raddr];
    end
    if (tbl_we) begin
      tbl_sum_mem[s2_addr_q]  <= new_sum;
      tbl_peak_mem[s2_addr_q] <= new_peak;
    end
    if (clr_active) begin
      tbl_tag_mem[clr_q] <= '0;
    end else if (tbl_we) begin
      tbl_tag_mem[s2_addr_q] <= s2_epoch_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: total and peak update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_kind_q  <= s1_kind_q;
      s2_thr_q   <= s1_thr_q;
      s2_zone_q  <= zone1;
      s2_start_q <= start1;
      s2_el_q    <= el1;
      s2_level_q <= s1_level_q;
      s2_fnum_q  <= s1_fnum_q;
      s2_epoch_q <= s1_epoch_q;
      s2_addr_q  <= tbl_raddr;
    end
  end

  always_comb begin
    is_pop2   = (s2_kind_q == KIND_ZONE_CLOSED);
    // the entry read last step may be the one written at that same edge
    fwd       = lw_valid_q && (lw_addr_q == s2_addr_q);
    hit       = fwd ? (lw_epoch_q == s2_epoch_q) : (tag_rd_q == s2_epoch_q);
    prev_sum  = fwd ? lw_sum_q : sum_rd_q;
    prev_peak = fwd ? lw_peak_q : peak_rd_q;
    new_sum   = hit ? prev_sum + s2_el_q : s2_el_q;
    new_peak  = (hit && prev_peak > s2_el_q) ? prev_peak : s2_el_q;
    tbl_we    = adv && s2_valid_q && is_pop2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else if (clr_active) begin
      lw_valid_q <= 1'b0;
    end else if (adv) begin
      lw_valid_q <= tbl_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lw_addr_q  <= s2_addr_q;
      lw_sum_q   <= new_sum;
      lw_peak_q  <= new_peak;
      lw_epoch_q <= s2_epoch_q;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_kind_q  <= s2_kind_q;
      out_thr_q   <= s2_thr_q;
      out_zone_q  <= s2_zone_q;
      out_start_q <= s2_start_q;
      out_el_q    <= s2_el_q;
      out_level_q <= s2_level_q;
      out_total_q <= is_pop2 ? new_sum : '0;
      out_max_q   <= is_pop2 ? new_peak : '0;
      out_fnum_q  <= s2_fnum_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_kind_q;
  assign res_o.out_thread   = out_thr_q;
  assign res_o.out_zone     = out_zone_q;
  assign res_o.start_time   = out_start_q;
  assign res_o.elapsed      = out_el_q;
  assign res_o.level        = out_level_q;
  assign res_o.zone_total   = out_total_q;
  assign res_o.zone_max     = out_max_q;
  assign res_o.frame_number = out_fnum_q;

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> sp_cur <= SPW'(STACK_DEPTH))
    else $error("stack pointer past stack depth");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active |-> !s1_valid_q && !s2_valid_q)
    else $error("table clearing pass with items in flight");

  a_wrap_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && wrap) |=> state_q == ST_DRAIN)
    else $error("epoch rollover did not start a drain");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> epoch_q != '0)
    else $error("open frame with cleared epoch");

  a_res_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_valid_q) |=> res_o.valid)
    else $error("result item lost between stage 2 and output");
`endif

endmodule

>>> verif/nzt_span_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nzt_span_monitor: result checker for the nested zone timing tracker
// Watches the event, result and config ports, predicts the result of every
// accepted trace event and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module nzt_span_monitor
  import nzt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  nzt_evt_if   evt,
  nzt_res_if   res,
  output int   mismatches_o,
  output int   awaited_o
);

  localparam int unsigned THREADS = THREAD_COUNT_DEF;
  localparam int unsigned DEPTH   = STACK_DEPTH_DEF;
  localparam int unsigned ZONES   = ZONE_COUNT_DEF;

  typedef struct packed {
    kind_e               kind;
    logic [THREAD_W-1:0] out_thread;
    logic [ZONE_W-1:0]   out_zone;
    logic [TS_W-1:0]     start_time;
    logic [TS_W-1:0]     elapsed;
    logic [LEVEL_W-1:0]  level;
    logic [TS_W-1:0]     zone_total;
    logic [TS_W-1:0]     zone_max;
    logic [FNUM_W-1:0]   frame_number;
  } span_report_t;

  // mirror of the tracker state
  logic              stopped;
  logic              frame_open;
  logic [TS_W-1:0]   frame_t0;
  logic [FNUM_W-1:0] frames_closed;
  logic [4:0]        open_depth [THREADS];
  logic [TS_W-1:0]   open_t0    [THREADS][DEPTH];
  logic [ZONE_W-1:0] open_zone  [THREADS][DEPTH];
  logic [TS_W-1:0]   zone_sum   [THREADS][ZONES];
  logic [TS_W-1:0]   zone_peak  [THREADS][ZONES];
  logic              zone_live  [THREADS][ZONES];

  span_report_t awaited_reports [$];
  span_report_t next_report;
  span_report_t seen_report;
  bit           has_report;

  initial mismatches_o = 0;
  initial awaited_o    = 0;

  task automatic note_mismatch(input string msg);
    mismatches_o++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic time_trace_event(input mode_e m, input logic [THREAD_W-1:0] thr,
                                  input logic [ZONE_W-1:0] zid,
                                  input logic [TS_W-1:0] ts,
                                  output bit hit, output span_report_t r);
    logic [4:0]      sp;
    logic [TS_W-1:0] st;
    logic [TS_W-1:0] el;
    logic [ZONE_W-1:0] z;
    hit = 1'b0;
    r   = '0;
    if (!stopped) begin
      case (m)
        MODE_FRAME_START: begin
          if (frame_open) begin
            hit          = 1'b1;
            r.kind       = KIND_NESTED_FRAME;
            r.out_thread = thr;
            r.start_time = ts;
          end
          // both opening and restarting empty the stacks and clear the table
          frame_open = 1'b1;
          frame_t0   = ts;
          foreach (open_depth[t]) open_depth[t] = '0;
          foreach (zone_live[t, k]) zone_live[t][k] = 1'b0;
        end
        MODE_FRAME_END: begin
          if (frame_open) begin
            frames_closed  = frames_closed + 1'b1;
            frame_open     = 1'b0;
            hit            = 1'b1;
            r.kind         = KIND_FRAME_CLOSED;
            r.out_thread   = thr;
            r.start_time   = frame_t0;
            r.elapsed      = ts - frame_t0;
            r.frame_number = frames_closed;
          end
        end
        MODE_ZONE_START: begin
          if (frame_open) begin
            sp = open_depth[thr];
            if (sp >= DEPTH) begin
              hit          = 1'b1;
              r.kind       = KIND_OVERFLOW;
              r.out_thread = thr;
              r.out_zone   = zid;
              r.start_time = ts;
            end else begin
              open_t0[thr][sp]   = ts;
              open_zone[thr][sp] = zid;
              open_depth[thr]    = sp + 1'b1;
            end
          end
        end
        default: begin
          if (frame_open) begin
            sp  = open_depth[thr];
            hit = 1'b1;
            r.out_thread = thr;
            if (sp == 0) begin
              r.kind       = KIND_EMPTY_END;
              r.start_time = ts;
            end else begin
              sp              = sp - 1'b1;
              open_depth[thr] = sp;
              st              = open_t0[thr][sp];
              z               = open_zone[thr][sp];
              el              = ts - st;
              if (zone_live[thr][z % ZONES]) begin
                zone_sum[thr][z % ZONES] = zone_sum[thr][z % ZONES] + el;
                if (el > zone_peak[thr][z % ZONES]) zone_peak[thr][z % ZONES] = el;
              end else begin
                zone_sum[thr][z % ZONES]  = el;
                zone_peak[thr][z % ZONES] = el;
              end
              zone_live[thr][z % ZONES] = 1'b1;
              r.kind       = KIND_ZONE_CLOSED;
              r.out_zone   = z;
              r.start_time = st;
              r.elapsed    = el;
              r.level      = sp[LEVEL_W-1:0];
              r.zone_total = zone_sum[thr][z % ZONES];
              r.zone_max   = zone_peak[thr][z % ZONES];
            end
          end
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped       = 1'b0;
      frame_open    = 1'b0;
      frame_t0      = '0;
      frames_closed = '0;
      foreach (open_depth[t]) open_depth[t] = '0;
      foreach (zone_live[t, k]) zone_live[t][k] = 1'b0;
      awaited_reports.delete();
      awaited_o = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (awaited_reports.size() == 0) begin
          note_mismatch($sformatf("result of kind %0d with nothing awaited", res.kind));
        end else begin
          seen_report = awaited_reports.pop_front();
          check_field("kind", res.kind, seen_report.kind);
          check_field("out_thread", res.out_thread, seen_report.out_thread);
          check_field("out_zone", res.out_zone, seen_report.out_zone);
          check_field("start_time", res.start_time, seen_report.start_time);
          check_field("elapsed", res.elapsed, seen_report.elapsed);
          check_field("level", res.level, seen_report.level);
          check_field("zone_total", res.zone_total, seen_report.zone_total);
          check_field("zone_max", res.zone_max, seen_report.zone_max);
          check_field("frame_number", res.frame_number, seen_report.frame_number);
        end
      end
      if (evt.valid && evt.ready) begin
        time_trace_event(mode_e'(evt.mode), evt.thread_id, evt.zone_id, evt.timestamp,
                         has_report, next_report);
        if (has_report) awaited_reports = {awaited_reports, next_report};
      end
      if (cfg_we_i) stopped = cfg_wdata_i;
      awaited_o = awaited_reports.size();
    end
  end

endmodule

>>> verif/tb_nested_zone_timing_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nested_zone_timing_tracker_core: testbench of the zone timing tracker
// Directed corner events, then frame-structured random traces with random
// stalls on both channels and recording stop phases; a span monitor checks
// every result.
// ----------------------------------------------------------------------------
module tb_nested_zone_timing_tracker_core;
  import nzt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;
  bit   calm;
  int   mismatches;
  int   awaited;
  int   quiet_cycles;
  int   round;
  int   n;

  // shadow of the frame and stack state, used only to shape the traces
  logic        sh_in_frame;
  int          sh_depth [THREAD_COUNT_DEF];
  logic [2:0]  hot_thread;
  logic [63:0] clock_now;

  nzt_evt_if evt_bus ();
  nzt_res_if res_bus ();

  nested_zone_timing_tracker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_i       (evt_bus),
    .res_o       (res_bus)
  );

  nzt_span_monitor span_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .evt          (evt_bus),
    .res          (res_bus),
    .mismatches_o (mismatches),
    .awaited_o    (awaited)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    res_bus.ready <= calm || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk_i) begin
    if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL nested_zone_timing_tracker_core");
      $finish;
    end
  end

  task automatic send_event(input mode_e m, input logic [2:0] thr, input logic [5:0] zid,
                            input logic [63:0] ts);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 22) begin
      evt_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt_bus.valid     <= 1'b1;
    evt_bus.mode      <= m;
    evt_bus.thread_id <= thr;
    evt_bus.zone_id   <= zid;
    evt_bus.timestamp <= ts;
    do @(posedge clk_i); while (!evt_bus.ready);
  endtask

  // hold the sender until every awaited result is in, then let the pipe empty
  task automatic settle(input int extra);
    @(negedge clk_i);
    evt_bus.valid <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic set_recording_stop(input logic stop);
    settle(8);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= stop;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_noise_event();
    send_event(mode_e'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
               6'($urandom_range(0, 63)), {$urandom, $urandom});
  endtask

  task automatic send_random_event();
    mode_e       m;
    logic [2:0]  thr;
    logic [5:0]  zid;
    logic [63:0] ts;
    int          pick;
    int          tries;
    if ($urandom_range(0, 99) < 2) clock_now = {$urandom, $urandom};
    else clock_now = clock_now + 64'($urandom_range(1, 60));
    ts   = clock_now;
    thr  = 3'($urandom_range(0, 7));
    // few zone ids most of the time so totals and peaks accumulate
    zid  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 5));
    pick = $urandom_range(0, 99);
    if (!sh_in_frame) begin
      m = (pick < 90) ? MODE_FRAME_START : mode_e'($urandom_range(1, 3));
    end else if (pick < 3) begin
      m = MODE_FRAME_END;
    end else if (pick < 5) begin
      m = MODE_FRAME_START;
    end else if (pick < 57) begin
      m = MODE_ZONE_START;
      if (pick < 30) thr = hot_thread;
    end else if (pick < 97) begin
      m = MODE_ZONE_END;
      for (tries = 0; tries < 4 && sh_depth[thr] == 0; tries++) begin
        thr = 3'($urandom_range(0, 7));
      end
    end else begin
      m  = mode_e'($urandom_range(0, 3));
      ts = {$urandom, $urandom};
    end
    case (m)
      MODE_FRAME_START: begin
        sh_in_frame = 1'b1;
        foreach (sh_depth[t]) sh_depth[t] = 0;
        hot_thread = 3'($urandom_range(0, 7));
      end
      MODE_FRAME_END: sh_in_frame = 1'b0;
      MODE_ZONE_START: begin
        if (sh_in_frame && sh_depth[thr] < STACK_DEPTH_DEF) sh_depth[thr]++;
      end
      default: begin
        if (sh_in_frame && sh_depth[thr] > 0) sh_depth[thr]--;
      end
    endcase
    send_event(m, thr, zid, ts);
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = 1'b0;
    calm              = 1'b0;
    quiet_cycles      = 0;
    evt_bus.valid     = 1'b0;
    evt_bus.mode      = MODE_FRAME_START;
    evt_bus.thread_id = '0;
    evt_bus.zone_id   = '0;
    evt_bus.timestamp = '0;
    res_bus.ready     = 1'b0;
    sh_in_frame       = 1'b0;
    hot_thread        = '0;
    clock_now         = '0;
    foreach (sh_depth[t]) sh_depth[t] = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_recording_stop(1'b0);

    // events outside a frame are dropped
    send_event(MODE_ZONE_END, 3'd0, 6'd0, 64'd0);
    send_event(MODE_FRAME_END, 3'd7, 6'd63, '1);
    send_event(MODE_ZONE_START, 3'd3, 6'd21, 64'h1234);
    send_event(MODE_FRAME_START, 3'd0, 6'd0, 64'd0);
    send_event(MODE_ZONE_END, 3'd7, 6'd63, 64'h55);
    // fill thread 0 to the top, just below the timestamp wrap
    for (n = 0; n < STACK_DEPTH_DEF; n++) begin
      send_event(MODE_ZONE_START, 3'd0, (n == STACK_DEPTH_DEF - 1) ? 6'd63 : 6'(n),
                 64'hFFFF_FFFF_FFFF_FFF0 + 64'(n));
    end
    send_event(MODE_ZONE_START, 3'd0, 6'd42, 64'hFFFF_FFFF_FFFF_FFFF);
    send_event(MODE_ZONE_END, 3'd0, 6'd0, 64'd3);
    send_event(MODE_FRAME_START, 3'd5, 6'd0, '1);
    send_event(MODE_FRAME_END, 3'd7, 6'd0, 64'd0);

    for (round = 0; round < 2; round++) begin
      set_recording_stop(1'b1);
      repeat (40) send_noise_event();
      set_recording_stop(1'b0);
      for (n = 0; n < 1000; n++) begin
        calm = (n >= 300 && n < 550);
        if (n % 400 == 399) settle(0);
        send_random_event();
      end
      calm = 1'b0;
    end

    settle(20);
    if (mismatches == 0 && awaited == 0) begin
      $display("PASS nested_zone_timing_tracker_core");
    end else begin
      $display("FAIL nested_zone_timing_tracker_core");
    end
    $finish;
  end

endmodule
